@@ hdl/sxl_pkg.sv @@
// ----------------------------------------------------------------------------
// S-expression lexer package
// Shared types, character codes and classification functions.
// ----------------------------------------------------------------------------
package sxl_pkg;

   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] MAX_LEN_RESET = 8'd99;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_MINUS   = 3'd2,
      MODE_NUMBER  = 3'd3,
      MODE_SYMBOL  = 3'd4
   } mode_type;

   localparam logic [2:0] KIND_LPAREN = 3'd0;
   localparam logic [2:0] KIND_RPAREN = 3'd1;
   localparam logic [2:0] KIND_QUOTE  = 3'd2;
   localparam logic [2:0] KIND_NUMBER = 3'd3;
   localparam logic [2:0] KIND_SYMBOL = 3'd4;

   localparam logic [1:0] EV_CHAR   = 2'd0;
   localparam logic [1:0] EV_END    = 2'd1;
   localparam logic [1:0] EV_SINGLE = 2'd2;

   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_QUOTE   = 8'h27;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef logic [LEVEL_W-1:0] level_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [1:0] event_res;
      logic [7:0] char_value;
      logic       too_long;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      // tab, newline, vertical tab, form feed and carriage return are contiguous
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CHAR_LPAREN) || (c == CHAR_RPAREN) || (c == CHAR_QUOTE) || is_space(c);
   endfunction

   function automatic result_type make_result(input logic [2:0] kind,
                                              input logic [1:0] ev,
                                              input logic [7:0] ch,
                                              input logic       tl);
      result_type r;
      r.token_kind = kind;
      r.event_res  = ev;
      r.char_value = ch;
      r.too_long   = tl;
      r.last       = 1'b0;
      return r;
   endfunction

endpackage

@@ hdl/sxl_core.sv @@
// ----------------------------------------------------------------------------
// S-expression lexer core
// Lexer state and the single-pass classification of one character into up
// to three result words.
// ----------------------------------------------------------------------------
module sxl_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       char_in,
   input  logic [7:0]       max_len,
   output sxl_pkg::push_type push
);
   import sxl_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] len_ff, len_in;
   logic       ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= 8'd0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_comb begin
      mode_type                     mode;
      logic [7:0]                   len;
      logic                         ovf;
      logic [1:0]                   n;
      logic                         restart;
      result_type [MAX_RESULTS-1:0] res;

      mode    = mode_ff;
      len     = len_ff;
      ovf     = ovf_ff;
      n       = 2'd0;
      restart = 1'b0;
      res     = '0;

      case (mode_ff)
         MODE_COMMENT: begin
            if (char_in == CHAR_NEWLINE) mode = MODE_IDLE;
         end
         MODE_MINUS: begin
            if (is_digit(char_in)) begin
               mode = MODE_NUMBER;
               if (len < max_len) begin
                  len    = len + 8'd1;
                  res[n] = make_result(KIND_NUMBER, EV_CHAR, CHAR_MINUS, 1'b0);
                  n      = n + 2'd1;
               end else ovf = 1'b1;
               if (len < max_len) begin
                  len    = len + 8'd1;
                  res[n] = make_result(KIND_NUMBER, EV_CHAR, char_in, 1'b0);
                  n      = n + 2'd1;
               end else ovf = 1'b1;
            end else begin
               if (len < max_len) begin
                  len    = len + 8'd1;
                  res[n] = make_result(KIND_SYMBOL, EV_CHAR, CHAR_MINUS, 1'b0);
                  n      = n + 2'd1;
               end else ovf = 1'b1;
               if (is_delim(char_in)) begin
                  res[n]  = make_result(KIND_SYMBOL, EV_END, char_in, ovf);
                  n       = n + 2'd1;
                  restart = 1'b1;
               end else begin
                  mode = MODE_SYMBOL;
                  if (len < max_len) begin
                     len    = len + 8'd1;
                     res[n] = make_result(KIND_SYMBOL, EV_CHAR, char_in, 1'b0);
                     n      = n + 2'd1;
                  end else ovf = 1'b1;
               end
            end
         end
         MODE_NUMBER: begin
            if (is_digit(char_in)) begin
               if (len < max_len) begin
                  len    = len + 8'd1;
                  res[n] = make_result(KIND_NUMBER, EV_CHAR, char_in, 1'b0);
                  n      = n + 2'd1;
               end else ovf = 1'b1;
            end else begin
               res[n]  = make_result(KIND_NUMBER, EV_END, char_in, ovf);
               n       = n + 2'd1;
               restart = 1'b1;
            end
         end
         MODE_SYMBOL: begin
            if (is_delim(char_in)) begin
               res[n]  = make_result(KIND_SYMBOL, EV_END, char_in, ovf);
               n       = n + 2'd1;
               restart = 1'b1;
            end else begin
               if (len < max_len) begin
                  len    = len + 8'd1;
                  res[n] = make_result(KIND_SYMBOL, EV_CHAR, char_in, 1'b0);
                  n      = n + 2'd1;
               end else ovf = 1'b1;
            end
         end
         default: restart = 1'b1;
      endcase

      // treat the terminating character as the start of a new token
      if (restart) begin
         mode = MODE_IDLE;
         len  = 8'd0;
         ovf  = 1'b0;
         if (is_space(char_in)) begin
            mode = MODE_IDLE;
         end else if (char_in == CHAR_SEMI) begin
            mode = MODE_COMMENT;
         end else if (char_in == CHAR_LPAREN) begin
            res[n] = make_result(KIND_LPAREN, EV_SINGLE, char_in, 1'b0);
            n      = n + 2'd1;
         end else if (char_in == CHAR_RPAREN) begin
            res[n] = make_result(KIND_RPAREN, EV_SINGLE, char_in, 1'b0);
            n      = n + 2'd1;
         end else if (char_in == CHAR_QUOTE) begin
            res[n] = make_result(KIND_QUOTE, EV_SINGLE, char_in, 1'b0);
            n      = n + 2'd1;
         end else if (char_in == CHAR_MINUS) begin
            mode = MODE_MINUS;
         end else begin
            mode = is_digit(char_in) ? MODE_NUMBER : MODE_SYMBOL;
            if (len < max_len) begin
               len    = len + 8'd1;
               res[n] = make_result(is_digit(char_in) ? KIND_NUMBER : KIND_SYMBOL,
                                    EV_CHAR, char_in, 1'b0);
               n      = n + 2'd1;
            end else ovf = 1'b1;
         end
      end

      if (n != 2'd0) res[n - 2'd1].last = 1'b1;

      mode_in    = mode;
      len_in     = len;
      ovf_in     = ovf;
      push.count = accept ? n : 2'd0;
      push.res   = res;
   end

endmodule

@@ hdl/sxl_queue.sv @@
// ----------------------------------------------------------------------------
// S-expression lexer result buffer
// Shifting queue that takes up to three words per cycle and hands out one per cycle unless rsp_stall holds it.
// ----------------------------------------------------------------------------
module sxl_queue (
   input  logic                clock,
   input  logic                reset,
   input  sxl_pkg::push_type   push,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output sxl_pkg::result_type head,
   output sxl_pkg::level_type  level
);
   import sxl_pkg::*;

   result_type slots_ff [QUEUE_DEPTH];
   result_type slots_in [QUEUE_DEPTH];
   level_type  level_ff, level_in;
   level_type  wr_base;
   logic       pop;

   assign rsp_valid = (level_ff != '0);
   assign head      = slots_ff[0];
   assign level     = level_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_base   = level_ff - {{(LEVEL_W-1){1'b0}}, pop};
   assign level_in  = wr_base + {{(LEVEL_W-2){1'b0}}, push.count};

   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
         slots_in[j] = pop ? slots_ff[j + 1] : slots_ff[j];
      end
      slots_in[QUEUE_DEPTH - 1] = slots_ff[QUEUE_DEPTH - 1];
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if ((2'(i) < push.count) && (LEVEL_W'(j) == wr_base + LEVEL_W'(i)))
               slots_in[j] = push.res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) slots_ff[j] <= slots_in[j];
   end

endmodule

@@ hdl/sexpr_token_lexer.sv @@
// ----------------------------------------------------------------------------
// S-expression token lexer
// Classifies a byte stream into parentheses, quotes, numbers and symbols.
// ----------------------------------------------------------------------------
// One character is taken per cycle and classified in that cycle; its zero to
// three result words go into a four-word buffer, and one word leaves per
// cycle unless rsp_stall holds it. The input stalls while the buffer holds
// more than one word, so with no output stall, characters that each give at
// most one word run at one character per cycle; one giving two or three words
// stalls the input until the buffer drains to one word; output is registered.
module sexpr_token_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_kind,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_char_value,
   output logic       rsp_too_long,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_token_len
);
   import sxl_pkg::*;

   logic [7:0] max_len_ff;
   logic       accept;
   push_type   push;
   result_type head;
   level_type  level;

   assign csr_ready = 1'b1;
   assign req_stall = (level > LEVEL_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_token_len;
      end
   end

   sxl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .char_in (req_char_in),
      .max_len (max_len_ff),
      .push    (push)
   );

   sxl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .level     (level)
   );

   assign rsp_token_kind = head.token_kind;
   assign rsp_event_res  = head.event_res;
   assign rsp_char_value = head.char_value;
   assign rsp_too_long   = head.too_long;
   assign rsp_last       = head.last;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= LEVEL_W'(QUEUE_DEPTH))
      else $error("result buffer over capacity");

   a_level_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         level == $past(level) + {{(LEVEL_W-2){1'b0}}, $past(push.count)}
                  - {{(LEVEL_W-1){1'b0}}, $past(rsp_valid && !rsp_stall)})
      else $error("result buffer level out of step with words moved");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd1 || push.res[0].last)
      && (push.count != 2'd2 || (push.res[1].last && !push.res[0].last))
      && (push.count != 2'd3
          || (push.res[2].last && !push.res[1].last && !push.res[0].last)))
      else $error("last flag not on the final word of a character");

endmodule
